>>> rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  // Code unit for any malformed byte
  localparam logic [15:0] REPL_UNIT = 16'hFFFD;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] ASCII_MAX = 8'h7F;

  // Leads with a narrowed second-byte range
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;
  localparam logic [7:0] SEC_A0  = 8'hA0;
  localparam logic [7:0] SEC_90  = 8'h90;
  localparam logic [7:0] SEC_8F  = 8'h8F;

  // Surrogate construction
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // What follows the replacement units of one byte
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_PAIR   = 2'd2
  } point_kind_e;

  // Work for the back end: repl_cnt replacements, then the point units
  typedef struct packed {
    logic [2:0]  repl_cnt;
    point_kind_e kind;
    logic [15:0] unit_a;
    logic [15:0] unit_b;
  } desc_t;

endpackage

>>> rtl/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder.
// Usage:
//   Slave stream: one UTF-8 byte per transaction in s_axis_tdata_i, with
//   s_axis_tlast_i marking the last byte of a buffer. Master stream: one
//   UTF-16 code unit per transaction in m_axis_tdata_o; m_axis_tlast_o marks
//   the final unit caused by one input byte. Malformed bytes give U+FFFD,
//   one per byte; code points above U+FFFF give a surrogate pair.
// Timing:
//   A byte is taken every cycle while the descriptor queue has room
//   (FIFO_DEPTH entries). A byte's first unit passes the queue, then the
//   output register. The back end emits one code unit per cycle while the
//   receiver is ready; a byte yielding k units holds the output side
//   until all k leave; bytes that only extend a sequence push nothing.
// Reset: the open sequence is dropped, the queue and output register empty.
// Stall: a stalled receiver holds the output register; the queue then
//   fills and s_axis_tready_o falls until space returns.
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] code_unit
  output logic        m_axis_tlast_o    // last_of_run
);

  logic  accept;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  desc_t push_desc;
  desc_t head_desc;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  u8u16_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .eoi_i    (s_axis_tlast_i),
    .push_o   (push),
    .desc_o   (push_desc)
  );

  u8u16_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_desc)
  );

  u8u16_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head_desc),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_unit_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // A push never lands on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("descriptor pushed into full queue");

  // A pop needs a queued descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("descriptor popped from empty queue");

  // A high surrogate is always followed by its low half from the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[15:10] == 6'b110110) |-> !m_axis_tlast_o)
    else $error("high surrogate marked as last unit");
`endif

endmodule

>>> rtl/u8u16_front.sv
// Front end: sequence tracking and classification of each accepted byte.
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       eoi_i,
  output logic       push_o,
  output desc_t      desc_o
);

  logic [7:0]  lead_q, lead_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] part_q, part_d;

  logic        cont;
  logic        sec_ok;
  logic        next_ok;
  logic [2:0]  got;
  logic [20:0] cp_ext;
  logic [20:0] point;
  logic        has_pt;
  logic [2:0]  repl;
  logic [20:0] supp;

  // Classify the byte against the open sequence
  always_comb begin
    cont   = (byte_i[7:6] == 2'b10);
    sec_ok = cont
           && !(lead_q == LEAD_E0 && byte_i <  SEC_A0)
           && !(lead_q == LEAD_ED && byte_i >= SEC_A0)
           && !(lead_q == LEAD_F0 && byte_i <  SEC_90)
           && !(lead_q == LEAD_F4 && byte_i >  SEC_8F);
    next_ok = (cnt_q == 2'd1) ? sec_ok : cont;
    got     = {1'b0, cnt_q} + 3'd1;
    cp_ext  = {part_q[14:0], byte_i[5:0]};

    lead_d = lead_q;
    cnt_d  = cnt_q;
    len_d  = len_q;
    part_d = part_q;
    point  = '0;
    has_pt = 1'b0;
    repl   = '0;

    if (cnt_q != 2'd0 && next_ok) begin
      if (got >= len_q) begin
        has_pt = 1'b1;
        point  = cp_ext;
        lead_d = '0;
        cnt_d  = '0;
        len_d  = '0;
        part_d = '0;
      end else if (eoi_i) begin
        repl   = got;
        lead_d = '0;
        cnt_d  = '0;
        len_d  = '0;
        part_d = '0;
      end else begin
        part_d = cp_ext;
        cnt_d  = got[1:0];
      end
    end else begin
      // Flush any broken sequence, then treat the byte as fresh
      repl   = {1'b0, cnt_q};
      lead_d = '0;
      cnt_d  = '0;
      len_d  = '0;
      part_d = '0;
      if (byte_i <= ASCII_MAX) begin
        has_pt = 1'b1;
        point  = {13'd0, byte_i};
      end else if (byte_i >= LEAD2_LO && byte_i <= LEAD2_HI) begin
        lead_d = byte_i;
        len_d  = 3'd2;
        part_d = {16'd0, byte_i[4:0]};
        cnt_d  = 2'd1;
      end else if (byte_i >= LEAD3_LO && byte_i <= LEAD3_HI) begin
        lead_d = byte_i;
        len_d  = 3'd3;
        part_d = {17'd0, byte_i[3:0]};
        cnt_d  = 2'd1;
      end else if (byte_i >= LEAD4_LO && byte_i <= LEAD4_HI) begin
        lead_d = byte_i;
        len_d  = 3'd4;
        part_d = {18'd0, byte_i[2:0]};
        cnt_d  = 2'd1;
      end else begin
        repl = repl + 3'd1;
      end
      // End of input closes a freshly opened sequence
      if (eoi_i && cnt_d != 2'd0) begin
        repl   = repl + 3'd1;
        lead_d = '0;
        cnt_d  = '0;
        len_d  = '0;
        part_d = '0;
      end
    end
  end

  // Build the descriptor for the back end
  always_comb begin
    supp            = point - SUPP_BASE;
    desc_o.repl_cnt = repl;
    desc_o.kind     = KIND_NONE;
    desc_o.unit_a   = '0;
    desc_o.unit_b   = '0;
    if (has_pt) begin
      if (point[20:16] != 5'd0) begin
        desc_o.kind   = KIND_PAIR;
        desc_o.unit_a = HI_SURR | {6'd0, supp[19:10]};
        desc_o.unit_b = LO_SURR | {6'd0, supp[9:0]};
      end else begin
        desc_o.kind   = KIND_SINGLE;
        desc_o.unit_a = point[15:0];
      end
    end
  end

  assign push_o = accept_i && (repl != 3'd0 || has_pt);

  // Advance sequence state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      cnt_q  <= '0;
      len_q  <= '0;
      part_q <= '0;
    end else if (accept_i) begin
      lead_q <= lead_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
      part_q <= part_d;
    end
  end

endmodule

>>> rtl/u8u16_fifo.sv
// Short descriptor queue between the front and back ends.
module u8u16_fifo
  import u8u16_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  desc_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Write storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/u8u16_back.sv
// Back end: expands descriptors into code units behind an output register.
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  desc_t       head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_unit_o,
  output logic        out_last_o
);

  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] unit_q;
  logic        last_q;
  logic [2:0]  total;
  logic [2:0]  pos;
  logic [15:0] unit_sel;
  logic        last_sel;
  logic        load;

  // Pick the unit at the current position within the head descriptor
  always_comb begin
    case (head_i.kind)
      KIND_SINGLE: total = head_i.repl_cnt + 3'd1;
      KIND_PAIR:   total = head_i.repl_cnt + 3'd2;
      default:     total = head_i.repl_cnt;
    endcase
    pos = {1'b0, idx_q};
    if (pos < head_i.repl_cnt) begin
      unit_sel = REPL_UNIT;
    end else if (pos == head_i.repl_cnt) begin
      unit_sel = head_i.unit_a;
    end else begin
      unit_sel = head_i.unit_b;
    end
    last_sel = (pos + 3'd1 == total);
  end

  // Load the output register when it is free or being drained
  always_comb begin
    load        = head_valid_i && (!out_valid_q || out_ready_i);
    pop_o       = load && last_sel;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last_sel ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q <= unit_sel;
      last_q <= last_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_unit_o  = unit_q;
  assign out_last_o  = last_q;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

module testbench;
  import u8u16_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // One expected UTF-16 transaction on the master side
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_of_run;
  } utf16_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] in_byte
  logic        s_axis_tlast_i;   // end_of_input
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // [15:0] code_unit
  logic        m_axis_tlast_o;   // last_of_run

  // Decoder state as predicted from the accepted bytes
  logic [7:0]  dec_lead;
  logic [1:0]  dec_pending;
  logic [2:0]  dec_len;
  logic [20:0] dec_point;

  utf16_result_t utf16_units_q[$];
  int            mismatch_count;
  int            cycle_count;
  int            bytes_sent;
  int            hold_cycles;
  int            rx_stall;
  bit            idling_on;

  utf8_to_utf16_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Toggle the clock every half period
  always #4 clk_i = ~clk_i;

  // Pick an idle length: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Close the open sequence
  function automatic void clear_sequence();
    dec_lead    = '0;
    dec_pending = '0;
    dec_len     = '0;
    dec_point   = '0;
  endfunction

  // Work out the code units that one accepted byte causes and queue them
  function automatic void transcode_byte(input logic [7:0] in_b, input logic eoi);
    logic [15:0] units[4];
    int          nu;
    logic        fits;
    logic [20:0] point;
    logic [19:0] offs;
    int          got;
    utf16_result_t res;
    nu    = 0;
    fits  = 1'b0;
    point = {dec_point[14:0], in_b[5:0]};
    if (dec_pending != 2'd0) begin
      fits = (in_b[7:6] == 2'b10);
      // Narrow the second byte for the leads with restricted ranges
      if (dec_pending == 2'd1) begin
        if (dec_lead == LEAD_E0 && in_b < SEC_A0) fits = 1'b0;
        if (dec_lead == LEAD_ED && in_b >= SEC_A0) fits = 1'b0;
        if (dec_lead == LEAD_F0 && in_b < SEC_90) fits = 1'b0;
        if (dec_lead == LEAD_F4 && in_b > SEC_8F) fits = 1'b0;
      end
    end
    if (fits) begin
      got = dec_pending + 1;
      if (got >= dec_len) begin
        // Complete point: one unit or a surrogate pair
        if (point <= 21'h00FFFF) begin
          units[nu] = point[15:0]; nu++;
        end else begin
          offs = 20'(point - SUPP_BASE);
          units[nu] = HI_SURR | {6'd0, offs[19:10]}; nu++;
          units[nu] = LO_SURR | {6'd0, offs[9:0]}; nu++;
        end
        clear_sequence();
      end else if (eoi) begin
        repeat (got) begin
          units[nu] = REPL_UNIT; nu++;
        end
        clear_sequence();
      end else begin
        dec_point   = point;
        dec_pending = got[1:0];
      end
    end else begin
      // Flush a broken sequence, then handle the byte afresh
      repeat (dec_pending) begin
        units[nu] = REPL_UNIT; nu++;
      end
      clear_sequence();
      if (in_b <= ASCII_MAX) begin
        units[nu] = {8'h00, in_b}; nu++;
      end else if (in_b >= LEAD2_LO && in_b <= LEAD2_HI) begin
        dec_lead = in_b; dec_len = 3'd2; dec_point = {16'd0, in_b[4:0]}; dec_pending = 2'd1;
      end else if (in_b >= LEAD3_LO && in_b <= LEAD3_HI) begin
        dec_lead = in_b; dec_len = 3'd3; dec_point = {17'd0, in_b[3:0]}; dec_pending = 2'd1;
      end else if (in_b >= LEAD4_LO && in_b <= LEAD4_HI) begin
        dec_lead = in_b; dec_len = 3'd4; dec_point = {18'd0, in_b[2:0]}; dec_pending = 2'd1;
      end else begin
        units[nu] = REPL_UNIT; nu++;
      end
      if (eoi) begin
        repeat (dec_pending) begin
          units[nu] = REPL_UNIT; nu++;
        end
        clear_sequence();
      end
    end
    for (int i = 0; i < nu; i++) begin
      res.code_unit   = units[i];
      res.last_of_run = (i == nu - 1);
      utf16_units_q.insert(utf16_units_q.size(), res);
    end
  endfunction

  // Count one mismatch and print a line for the first 100
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < 100)
      $display("MISMATCH at cycle %0d: %s: got %h, expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Offer one byte, wait for its transaction, then predict its results
  task automatic send_byte(input logic [7:0] in_b, input logic eoi);
    int gap;
    gap = idling_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= in_b;
    s_axis_tlast_i  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready_o);
    transcode_byte(in_b, eoi);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every expected code unit has come out
  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    while (utf16_units_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Send one well-formed character of the given UTF-8 length
  task automatic send_char(input int len);
    logic [20:0] cp;
    logic [7:0]  seq[4];
    logic        eoi_end;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        do cp = 21'($urandom_range('h800, 'hFFFF));
        while (cp >= 21'hD800 && cp <= 21'hDFFF);
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    case (len)
      1: seq[0] = cp[7:0];
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    eoi_end = ($urandom_range(0, 99) < 8);
    for (int i = 0; i < len; i++) send_byte(seq[i], eoi_end && (i == len - 1));
  endtask

  // Send a byte from C0 to FF, up to two continuations and a breaking or final byte
  task automatic send_broken();
    int k;
    send_byte(8'($urandom_range('hC0, 'hFF)), 1'b0);
    k = $urandom_range(0, 2);
    repeat (k) send_byte(8'($urandom_range('h80, 'hBF)), 1'b0);
    if ($urandom_range(0, 1) == 0)
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    else
      send_byte(8'($urandom_range('h80, 'hBF)), 1'b1);
  endtask

  // Drive the master-side ready: long hold first, then random stalls
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles--;
    end else if (rx_stall > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (idling_on) rx_stall = pick_gap();
    end
  end

  // Compare each output transaction with the oldest expected unit
  always @(posedge clk_i) begin
    utf16_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (utf16_units_q.size() == 0) begin
        report_mismatch("unexpected code unit", m_axis_tdata_o, '0);
      end else begin
        want = utf16_units_q.pop_front();
        if (m_axis_tdata_o !== want.code_unit)
          report_mismatch("code_unit", m_axis_tdata_o, want.code_unit);
        if (m_axis_tlast_o !== want.last_of_run)
          report_mismatch("last_of_run", {15'd0, m_axis_tlast_o}, {15'd0, want.last_of_run});
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d units outstanding",
               cycle_count, utf16_units_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_ascii();
    idling_on = 1'b0;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_drain();
  endtask

  task automatic test_multibyte();
    idling_on = 1'b1;
    // Smallest two-byte point, smallest three-byte point, largest point
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
    wait_drain();
  endtask

  task automatic test_malformed();
    // Invalid leads and a stray continuation
    send_byte(8'hC0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    // Overlong, encoded surrogate, above the top of the code space
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0);
    send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b1);
    wait_drain();
  endtask

  task automatic test_truncation();
    // Three pending bytes broken by ASCII, then a cut at end of input
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
    wait_drain();
  endtask

  task automatic test_backpressure();
    // Hold the receiver while the sender keeps offering
    idling_on   = 1'b0;
    hold_cycles = 150;
    repeat (12) send_char($urandom_range(1, 4));
    wait_drain();
  endtask

  task automatic test_random_text();
    int r;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 120) begin
      // Alternate idling stretches with back-to-back stretches
      idling_on = (((bytes_sent - start) / 40) % 3) != 2;
      r = $urandom_range(0, 99);
      if (r < 75) send_char($urandom_range(1, 4));
      else if (r < 88) send_broken();
      else send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    wait_drain();
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    bytes_sent      = 0;
    hold_cycles     = 0;
    rx_stall        = 0;
    idling_on       = 1'b0;
    clear_sequence();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_ascii();
    test_multibyte();
    test_malformed();
    test_truncation();
    test_backpressure();
    test_random_text();

    // Let any stray output show up before the verdict
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && utf16_units_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_fifo.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_decoder.sv
tb/sv/testbench.sv
